FILE: src/dtc_pkg.sv
// Shared types and constants of the depthwise transposed 1D convolution block.
`default_nettype none
package dtc_pkg;

   localparam int MAX_CHANNELS = 64;
   localparam int MAX_TAPS     = 16;
   localparam int MAX_ROW      = 4096;

   localparam int CH_W   = $clog2(MAX_CHANNELS);
   localparam int TAP_W  = $clog2(MAX_TAPS);
   localparam int POS_W  = $clog2(MAX_ROW);
   localparam int OPOS_W = 13;
   localparam int VAL_W  = 16;
   localparam int ACC_W  = 40;
   localparam int PROD_W = 2 * VAL_W;
   localparam int CC_W   = 7;
   localparam int KW_W   = 5;
   localparam int ADDR_W = TAP_W + CH_W;

   localparam logic CSR_CHANNEL_COUNT = 1'b0;
   localparam logic CSR_KERNEL_WIDTH  = 1'b1;

   localparam logic OP_KERNEL = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic                    op;
      logic [CH_W-1:0]         channel;
      logic [TAP_W-1:0]        tap;
      logic signed [VAL_W-1:0] value;
      logic                    row_end;
      logic [POS_W-1:0]        position;
      logic [KW_W-1:0]         taps;
   } cmd_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] out_value;
      logic [CH_W-1:0]         out_channel;
      logic [OPOS_W-1:0]       out_position;
      logic                    last;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_MUL,
      BK_ACC,
      BK_EMIT
   } bk_state_type;

endpackage
`default_nettype wire

FILE: src/depthwise_transposed_conv1d.sv
// Top level of the depthwise transposed 1D convolution block.
//
//   channel   direction  handshake                 payload
//   req_      in         push / full               op, channel, tap, value, row_end
//   rsp_      out        empty / pop               out_value, out_channel, out_position, last
//   csr_      in         csr_valid / csr_ready     csr_index, csr_data
//
// A kernel write is stored as the back end takes it. A sample is stored likewise; then,
// for each result, each contributing tap passes memory read, multiply and accumulate, and
// the result is emitted when the result queue has room, all on the single tap-serial unit.
// Reset is synchronous and clears the queues, the sequencer, position and configuration;
// the kernel and history memories are not cleared.
// A four-entry command queue and a four-entry result queue let either side stall alone.
`default_nettype none
module depthwise_transposed_conv1d
   import dtc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   output logic                         full,
   input  wire logic                    req_op,
   input  wire logic [CH_W-1:0]         req_channel,
   input  wire logic [TAP_W-1:0]        req_tap,
   input  wire logic signed [VAL_W-1:0] req_value,
   input  wire logic                    req_row_end,
   output logic                         empty,
   input  wire logic                    pop,
   output logic signed [ACC_W-1:0]      rsp_out_value,
   output logic [CH_W-1:0]              rsp_out_channel,
   output logic [OPOS_W-1:0]            rsp_out_position,
   output logic                         rsp_last,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic                    csr_index,
   input  wire logic [CC_W-1:0]         csr_data
);
   cmd_type cmd_in, cmd_out;
   rsp_type rsp_in, rsp_out;
   logic    accept, cmd_empty, cmd_pop, rsp_push, rsp_full;

   assign accept = push && !full;

   dtc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .op        (req_op),
      .channel   (req_channel),
      .tap       (req_tap),
      .value     (req_value),
      .row_end   (req_row_end),
      .cmd       (cmd_in)
   );

   dtc_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(4)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .wdata (cmd_in),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (cmd_out),
      .empty (cmd_empty)
   );

   dtc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_out),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_in),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   dtc_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(4)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_in),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_out),
      .empty (empty)
   );

   assign rsp_out_value    = rsp_out.out_value;
   assign rsp_out_channel  = rsp_out.out_channel;
   assign rsp_out_position = rsp_out.out_position;
   assign rsp_last         = rsp_out.last;

endmodule
`default_nettype wire

FILE: src/dtc_fifo.sv
// Small synchronous queue used between the front end, the back end and the result port.
`default_nettype none
module dtc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == AW'(0) + (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

FILE: src/dtc_front.sv
// Front end: configuration registers, position tracking and command formation.
`default_nettype none
module dtc_front
   import dtc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic                    csr_index,
   input  wire logic [CC_W-1:0]         csr_data,
   input  wire logic                    accept,
   input  wire logic                    op,
   input  wire logic [CH_W-1:0]         channel,
   input  wire logic [TAP_W-1:0]        tap,
   input  wire logic signed [VAL_W-1:0] value,
   input  wire logic                    row_end,
   output cmd_type                      cmd
);
   logic [CC_W-1:0]  channel_count_ff, channel_count_in;
   logic [KW_W-1:0]  kernel_width_ff, kernel_width_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [CC_W-1:0]  eff_channels;
   logic [KW_W-1:0]  eff_taps;
   logic             last_channel;

   assign csr_ready = 1'b1;

   always_comb begin
      if (channel_count_ff == '0) begin
         eff_channels = CC_W'(1);
      end else if (channel_count_ff > CC_W'(MAX_CHANNELS)) begin
         eff_channels = CC_W'(MAX_CHANNELS);
      end else begin
         eff_channels = channel_count_ff;
      end
      if (kernel_width_ff == '0) begin
         eff_taps = KW_W'(1);
      end else if (kernel_width_ff > KW_W'(MAX_TAPS)) begin
         eff_taps = KW_W'(MAX_TAPS);
      end else begin
         eff_taps = kernel_width_ff;
      end
   end

   assign last_channel = ({1'b0, channel} == eff_channels - CC_W'(1));

   always_comb begin
      channel_count_in = channel_count_ff;
      kernel_width_in  = kernel_width_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: channel_count_in = csr_data;
            CSR_KERNEL_WIDTH:  kernel_width_in  = csr_data[KW_W-1:0];
            default: ;
         endcase
      end
   end

   // The position moves on after the last channel of a position, and restarts on a row end.
   always_comb begin
      position_in = position_ff;
      if (accept && op == OP_SAMPLE && last_channel) begin
         if (row_end || position_ff == POS_W'(MAX_ROW - 1)) begin
            position_in = '0;
         end else begin
            position_in = position_ff + POS_W'(1);
         end
      end
   end

   always_comb begin
      cmd.op       = op;
      cmd.channel  = channel;
      cmd.tap      = tap;
      cmd.value    = value;
      cmd.row_end  = row_end;
      cmd.position = position_ff;
      cmd.taps     = eff_taps;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CC_W'(1);
         kernel_width_ff  <= KW_W'(1);
         position_ff      <= '0;
      end else begin
         channel_count_ff <= channel_count_in;
         kernel_width_ff  <= kernel_width_in;
         position_ff      <= position_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/dtc_back.sv
// Back end: kernel and history memories and the tap-serial multiply-accumulate sequencer.
`default_nettype none
module dtc_back
   import dtc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire cmd_type cmd,
   input  wire logic cmd_empty,
   output logic      cmd_pop,
   output rsp_type   rsp,
   output logic      rsp_push,
   input  wire logic rsp_full
);
   logic signed [VAL_W-1:0] kernel_mem  [MAX_TAPS * MAX_CHANNELS];
   logic signed [VAL_W-1:0] history_mem [MAX_TAPS * MAX_CHANNELS];

   bk_state_type            state_ff, state_in;
   cmd_type                 job_ff, job_in;
   logic [TAP_W-1:0]        k_ff, k_in;
   logic [TAP_W-1:0]        j_ff, j_in;
   logic [OPOS_W-1:0]       outpos_ff, outpos_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [VAL_W-1:0] kdata_ff, hdata_ff;

   logic              kmem_we, hmem_we, mem_re;
   logic [ADDR_W-1:0] kmem_waddr, hmem_waddr, kmem_raddr, hmem_raddr;
   logic              last_tap, last_out;

   assign kmem_waddr = {cmd.tap, cmd.channel};
   assign hmem_waddr = {cmd.position[TAP_W-1:0], cmd.channel};
   assign kmem_raddr = {k_ff, job_ff.channel};
   assign hmem_raddr = {outpos_ff[TAP_W-1:0] - k_ff, job_ff.channel};

   // Taps run from j up to the kernel end, but never reach before the row start.
   assign last_tap = ({1'b0, k_ff} + KW_W'(1) >= job_ff.taps) ||
                     (OPOS_W'(k_ff) >= outpos_ff);
   assign last_out = !job_ff.row_end || ({1'b0, j_ff} == job_ff.taps - KW_W'(1));

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      outpos_in = outpos_ff;
      acc_in    = acc_ff;
      cmd_pop   = 1'b0;
      kmem_we   = 1'b0;
      hmem_we   = 1'b0;
      mem_re    = 1'b0;
      rsp_push  = 1'b0;
      rsp.out_value    = acc_ff;
      rsp.out_channel  = job_ff.channel;
      rsp.out_position = outpos_ff;
      rsp.last         = last_out;
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               job_in    = cmd;
               k_in      = '0;
               j_in      = '0;
               outpos_in = OPOS_W'(cmd.position);
               acc_in    = '0;
               if (cmd.op == OP_KERNEL) begin
                  kmem_we = 1'b1;
               end else begin
                  hmem_we  = 1'b1;
                  state_in = BK_READ;
               end
            end
         end
         BK_READ: begin
            mem_re   = 1'b1;
            state_in = BK_MUL;
         end
         BK_MUL: begin
            state_in = BK_ACC;
         end
         BK_ACC: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            if (last_tap) begin
               state_in = BK_EMIT;
            end else begin
               k_in     = k_ff + TAP_W'(1);
               state_in = BK_READ;
            end
         end
         BK_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (last_out) begin
                  state_in = BK_IDLE;
               end else begin
                  j_in      = j_ff + TAP_W'(1);
                  k_in      = j_ff + TAP_W'(1);
                  outpos_in = outpos_ff + OPOS_W'(1);
                  acc_in    = '0;
                  state_in  = BK_READ;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      outpos_ff <= outpos_in;
      acc_ff    <= acc_in;
      prod_ff   <= kdata_ff * hdata_ff;
   end

   always_ff @(posedge clock) begin
      if (kmem_we) begin
         kernel_mem[kmem_waddr] <= cmd.value;
      end
      if (mem_re) begin
         kdata_ff <= kernel_mem[kmem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (hmem_we) begin
         history_mem[hmem_waddr] <= cmd.value;
      end
      if (mem_re) begin
         hdata_ff <= history_mem[hmem_raddr];
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full) else $error("result pushed into a full queue");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_ACC) |-> ({1'b0, k_ff} < job_ff.taps))
      else $error("tap index beyond kernel width");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == BK_IDLE && !cmd_empty))
      else $error("command taken outside idle");

   a_read_then_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_READ) |=> (state_ff == BK_MUL))
      else $error("memory read not followed by multiply");

endmodule
`default_nettype wire

FILE: sim/dtc_checker.sv
// Transaction checker that predicts and compares the results of the convolution block.
`timescale 1ns / 100ps
`default_nettype none
module dtc_checker
   import dtc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire logic                    full,
   input  wire logic                    req_op,
   input  wire logic [CH_W-1:0]         req_channel,
   input  wire logic [TAP_W-1:0]        req_tap,
   input  wire logic signed [VAL_W-1:0] req_value,
   input  wire logic                    req_row_end,
   input  wire logic                    empty,
   input  wire logic                    pop,
   input  wire logic signed [ACC_W-1:0] rsp_out_value,
   input  wire logic [CH_W-1:0]         rsp_out_channel,
   input  wire logic [OPOS_W-1:0]       rsp_out_position,
   input  wire logic                    rsp_last,
   input  wire logic                    csr_valid,
   input  wire logic                    csr_ready,
   input  wire logic                    csr_index,
   input  wire logic [CC_W-1:0]         csr_data,
   output int                           fail_count,
   output int                           pending
);

   logic signed [VAL_W-1:0] taps_mem [MAX_TAPS][MAX_CHANNELS];
   logic signed [VAL_W-1:0] history  [MAX_TAPS][MAX_CHANNELS];
   logic [OPOS_W-1:0]       position;
   logic [CC_W-1:0]         chan_reg;
   logic [KW_W-1:0]         width_reg;
   rsp_type                 expected_outputs[$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic int active_channels();
      if (chan_reg == 0) return 1;
      if (chan_reg > MAX_CHANNELS) return MAX_CHANNELS;
      return chan_reg;
   endfunction

   function automatic int active_taps();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_TAPS) return MAX_TAPS;
      return width_reg;
   endfunction

   // Only taps that reach back to position zero or later contribute.
   function automatic longint tap_sum(int ch, int outpos, int kfirst, int kw);
      longint acc;
      acc = 0;
      for (int k = kfirst; k < kw && k <= outpos; k++) begin
         acc += longint'(taps_mem[k][ch]) * longint'(history[(outpos - k) % MAX_TAPS][ch]);
      end
      return acc;
   endfunction

   task automatic predict_sample();
      int      kw;
      int      p;
      int      ch;
      rsp_type r;
      kw = active_taps();
      p = position;
      ch = req_channel;
      history[p % MAX_TAPS][ch] = req_value;
      r.out_value = ACC_W'(tap_sum(ch, p, 0, kw));
      r.out_channel = req_channel;
      r.out_position = OPOS_W'(p);
      r.last = !req_row_end || kw == 1;
      expected_outputs.push_back(r);
      if (req_row_end) begin
         for (int j = 1; j < kw; j++) begin
            r.out_value = ACC_W'(tap_sum(ch, p + j, j, kw));
            r.out_position = OPOS_W'(p + j);
            r.last = (j == kw - 1);
            expected_outputs.push_back(r);
         end
      end
      if (ch == active_channels() - 1) begin
         if (req_row_end || p + 1 >= MAX_ROW) position <= '0;
         else position <= OPOS_W'(p + 1);
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         expected_outputs.delete();
         position <= '0;
         chan_reg <= CC_W'(1);
         width_reg <= KW_W'(1);
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CHANNEL_COUNT) chan_reg <= csr_data;
            else width_reg <= csr_data[KW_W-1:0];
         end
         if (pop && !empty) begin
            if (expected_outputs.size() == 0) begin
               report($sformatf("unexpected result ch %0d pos %0d",
                                rsp_out_channel, rsp_out_position));
            end else begin
               e = expected_outputs.pop_front();
               if (rsp_out_value !== e.out_value)
                  report($sformatf("out_value %0d, expected %0d", rsp_out_value, e.out_value));
               if (rsp_out_channel !== e.out_channel)
                  report($sformatf("out_channel %0d, expected %0d",
                                   rsp_out_channel, e.out_channel));
               if (rsp_out_position !== e.out_position)
                  report($sformatf("out_position %0d, expected %0d",
                                   rsp_out_position, e.out_position));
               if (rsp_last !== e.last)
                  report($sformatf("last %0b, expected %0b", rsp_last, e.last));
            end
         end
         if (push && !full) begin
            if (req_op == OP_KERNEL) taps_mem[req_tap][req_channel] = req_value;
            else predict_sample();
         end
      end
      pending = expected_outputs.size();
   end

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the convolution block.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import dtc_pkg::*;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int FILL_CHANNELS = 6;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    push = 1'b0;
   logic                    full;
   logic                    req_op = OP_KERNEL;
   logic [CH_W-1:0]         req_channel = '0;
   logic [TAP_W-1:0]        req_tap = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    req_row_end = 1'b0;
   logic                    empty;
   logic                    pop = 1'b0;
   logic signed [ACC_W-1:0] rsp_out_value;
   logic [CH_W-1:0]         rsp_out_channel;
   logic [OPOS_W-1:0]       rsp_out_position;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic                    csr_index = CSR_CHANNEL_COUNT;
   logic [CC_W-1:0]         csr_data = '0;
   int                      fail_count;
   int                      pending;
   int                      send_idle = 0;
   int                      recv_idle = 0;
   int                      hold_off = 0;
   int                      cycles = 0;
   int                      samples_sent = 0;
   int                      rows_sent = 0;

   depthwise_transposed_conv1d dut (.*);

   dtc_checker checker_i (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("depthwise_transposed_conv1d regression: fail");
         $finish;
      end
   end

   // The receiver stalls at random, or holds off entirely while hold_off runs down.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_off > 0) begin
         pop <= 1'b0;
         hold_off--;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic logic signed [VAL_W-1:0] rand_value();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return VAL_W'($urandom_range(16'hffff));
      endcase
   endfunction

   // Called and returning at a falling edge; push stays high between back-to-back items.
   task automatic send(input logic op, input int ch, input int tp,
                       input logic signed [VAL_W-1:0] val, input logic re);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_op <= op;
      req_channel <= CH_W'(ch);
      req_tap <= TAP_W'(tp);
      req_value <= val;
      req_row_end <= re;
      do @(posedge clock); while (full);
      if (op == OP_SAMPLE) samples_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // Kernel writes leave nothing to wait for, so give the back end time to settle.
   task automatic write_csr(input logic idx, input int data);
      wait_drained();
      repeat (50) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CC_W'(data);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int cc, input int kw);
      write_csr(CSR_CHANNEL_COUNT, cc);
      write_csr(CSR_KERNEL_WIDTH, kw);
   endtask

   function automatic int clamp(input int v, input int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic send_row(input int positions, input int channels);
      for (int p = 0; p < positions; p++) begin
         for (int c = 0; c < channels; c++) begin
            send(OP_SAMPLE, c, $urandom_range(15), rand_value(), p == positions - 1);
         end
      end
      rows_sent++;
   endtask

   task automatic random_phase(input int target);
      int cc;
      int kw;
      int start;
      start = samples_sent;
      while (samples_sent - start < target) begin
         case ($urandom_range(9))
            0: cc = 0;
            1: cc = 127;
            2: cc = MAX_CHANNELS;
            default: cc = $urandom_range(1, 6);
         endcase
         case ($urandom_range(9))
            0: kw = 0;
            1: kw = 31;
            default: kw = $urandom_range(1, MAX_TAPS);
         endcase
         configure(cc, kw);
         cc = clamp(cc, MAX_CHANNELS);
         if (cc > FILL_CHANNELS) cc = FILL_CHANNELS;
         for (int r = 0; r < 3; r++) begin
            case ($urandom_range(7))
               0: send(OP_KERNEL, $urandom_range(63), $urandom_range(15), rand_value(), 1'b0);
               1: send(OP_SAMPLE, $urandom_range(FILL_CHANNELS - 1), $urandom_range(15),
                       rand_value(), 1'($urandom_range(1)));
               default: send_row($urandom_range(1, 5), cc);
            endcase
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill every kernel tap and history slot of the channels in use, so that no read
      // hits an unwritten entry.
      for (int t = 0; t < MAX_TAPS; t++) begin
         for (int c = 0; c < FILL_CHANNELS; c++) begin
            send(OP_KERNEL, c, t, rand_value(), 1'b0);
         end
      end
      configure(FILL_CHANNELS, 1);
      send_row(MAX_TAPS, FILL_CHANNELS);

      // Directed: extreme taps and samples, full tails, clamped registers.
      configure(2, 3);
      for (int t = 0; t < 3; t++) begin
         send(OP_KERNEL, 0, t, 16'sh8000, 1'b0);
         send(OP_KERNEL, 1, t, 16'sh7fff, 1'b0);
      end
      send(OP_SAMPLE, 0, 0, 16'sh8000, 1'b0);
      send(OP_SAMPLE, 1, 15, 16'sh7fff, 1'b0);
      send(OP_SAMPLE, 0, 0, 16'sh8000, 1'b1);
      send(OP_SAMPLE, 1, 0, 16'sh8000, 1'b1);
      // A channel at or above the channel count never moves the position.
      send(OP_SAMPLE, 4, 0, 16'sh7fff, 1'b0);
      send(OP_SAMPLE, 5, 0, 16'sh0001, 1'b1);
      configure(0, 0);
      send_row(2, 1);
      configure(127, 31);
      send(OP_SAMPLE, 0, 0, 16'sh7fff, 1'b0);
      send(OP_SAMPLE, 5, 0, 16'sh8000, 1'b1);
      configure(1, 16);
      send_row(3, 1);

      send_idle = 18;
      recv_idle = 55;
      configure(4, 8);
      hold_off = 400;
      send_row(6, 4);
      random_phase(40);

      send_idle = 55;
      recv_idle = 18;
      random_phase(40);
      wait_drained();

      send_idle = 0;
      recv_idle = 0;
      random_phase(40);

      push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (200) @(posedge clock);

      $display("covered %0d samples in %0d rows, kernel writes, clamped registers,",
               samples_sent, rows_sent);
      $display("stray channels and long receiver stalls in %0d cycles", cycles);
      if (fail_count == 0) begin
         $display("depthwise_transposed_conv1d regression: pass");
      end else begin
         $display("depthwise_transposed_conv1d regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
src/dtc_pkg.sv
src/dtc_fifo.sv
src/dtc_front.sv
src/dtc_back.sv
src/depthwise_transposed_conv1d.sv
sim/dtc_checker.sv
sim/tb.sv
